@@ rtl/core/egd_pkg.sv @@
package egd_pkg;

    // Longest zero prefix that still decodes; one more zero flags overflow.
    localparam int MAX_PREFIX = 31;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 32;
    localparam int ZC_W    = $clog2(MAX_PREFIX + 2);
    localparam int SL_W    = $clog2(MAX_PREFIX + 1);
    localparam int IDX_W   = $clog2(BYTE_W);

    // Decoder state carried from byte to byte. The accumulator holds the
    // leading one bit followed by the suffix bits, so value = accum - 1.
    typedef struct packed {
        logic               phase;
        logic [ZC_W-1:0]    zero_count;
        logic [SL_W-1:0]    suffix_left;
        logic [VALUE_W-1:0] suffix_accum;
    } dec_state_t;

    // One decoded codeword before the final decrement.
    typedef struct packed {
        logic [VALUE_W-1:0] raw;
        logic               ovf;
    } slot_t;

endpackage

@@ rtl/core/egd_walk.sv @@
module egd_walk
    import egd_pkg::*;
(
    input  logic [BYTE_W-1:0]      data_byte,
    input  logic                   unit_start,
    input  dec_state_t             state_cur,
    output dec_state_t             state_nxt,
    output logic [BYTE_W-1:0]      emit_mask,
    output slot_t [BYTE_W-1:0]     slots
);

    dec_state_t      s;
    logic            bit_v;
    logic [ZC_W-1:0] zc_inc;

    // Walk the byte MSB first; slot i belongs to the i-th bit consumed.
    always_comb
    begin
        s         = unit_start ? '0 : state_cur;
        bit_v     = 1'b0;
        zc_inc    = '0;
        emit_mask = '0;
        slots     = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            bit_v = data_byte[BYTE_W-1-i];
            if (!s.phase)
            begin
                if (!bit_v)
                begin
                    zc_inc = s.zero_count + ZC_W'(1);
                    if (zc_inc > ZC_W'(MAX_PREFIX))
                    begin
                        // prefix too long: flag it and restart the count
                        emit_mask[i]  = 1'b1;
                        slots[i].ovf  = 1'b1;
                        s             = '0;
                    end
                    else
                    begin
                        s.zero_count = zc_inc;
                    end
                end
                else if (s.zero_count == '0)
                begin
                    // lone one bit decodes to zero
                    emit_mask[i] = 1'b1;
                    slots[i].raw = VALUE_W'(1);
                end
                else
                begin
                    s.phase        = 1'b1;
                    s.suffix_left  = s.zero_count[SL_W-1:0];
                    s.suffix_accum = VALUE_W'(1);
                end
            end
            else
            begin
                s.suffix_accum = {s.suffix_accum[VALUE_W-2:0], bit_v};
                s.suffix_left  = s.suffix_left - SL_W'(1);
                if (s.suffix_left == '0)
                begin
                    emit_mask[i] = 1'b1;
                    slots[i].raw = s.suffix_accum;
                    s            = '0;
                end
            end
        end
        state_nxt = s;
    end

endmodule

@@ rtl/core/exp_golomb_ue_decoder.sv @@
// Unsigned Exp-Golomb ue(v) decoder.
// Input channel (in_valid / in_stall): one bitstream byte per item, MSB
// first, with unit_start set on the first byte of a unit to drop any partial
// codeword. Output channel (out_valid / out_stall): one decoded codeword per
// item with code_value, overflow (prefix longer than 31 zeros, value 0) and
// last_in_byte on the final codeword a byte completes. A byte that finishes
// no codeword produces no output item.
// A codeword's byte passes through the byte register, then the result
// slots, then the output register.
// Throughput: one byte per cycle while each byte yields at most one
// codeword and out_stall is low; a byte yielding several codewords holds
// the result slots while the output register drains one slot per unstalled cycle.
// Reset clears the decoder state, the pending slots and both valid flags.
// When the receiver stalls, the output register holds its item, the slots
// stay full, and in_stall rises once the byte register is occupied; no item
// is dropped or repeated.
module exp_golomb_ue_decoder
    import egd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic                unit_start,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [VALUE_W-1:0]  code_value,
    output logic                overflow,
    output logic                last_in_byte
);

    // byte register
    logic               byte_valid_reg, byte_valid_next;
    logic [BYTE_W-1:0]  byte_reg;
    logic               start_reg;

    // decoder state and result slots
    dec_state_t          state_reg;
    dec_state_t          walk_state;
    logic [BYTE_W-1:0]   walk_mask;
    slot_t [BYTE_W-1:0]  walk_slots;
    slot_t [BYTE_W-1:0]  slots_reg;
    logic [BYTE_W-1:0]   pend_reg, pend_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] code_value_reg;
    logic               overflow_reg;
    logic               last_reg;

    logic               accept;
    logic               out_load;
    logic               drain;
    logic               byte_move;
    logic [BYTE_W-1:0]  first_hot;
    logic [IDX_W-1:0]   first_idx;
    logic               found;
    slot_t              sel_slot;

    egd_walk u_walk (
        .data_byte  (byte_reg),
        .unit_start (start_reg),
        .state_cur  (state_reg),
        .state_nxt  (walk_state),
        .emit_mask  (walk_mask),
        .slots      (walk_slots)
    );

    // Pick the earliest pending codeword in bit order.
    always_comb
    begin
        first_hot = '0;
        first_idx = '0;
        found     = 1'b0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (pend_reg[i] && !found)
            begin
                found        = 1'b1;
                first_hot[i] = 1'b1;
                first_idx    = IDX_W'(i);
            end
        end
    end

    assign sel_slot = slots_reg[first_idx];

    // Advance the output register when it is empty or being taken.
    assign out_load  = !out_valid_reg || !out_stall;
    assign drain     = found && out_load;

    // Move the byte into the slots once the slots empty this cycle.
    assign byte_move = byte_valid_reg && ((pend_reg & ~(drain ? first_hot : '0)) == '0);
    assign in_stall  = byte_valid_reg && !byte_move;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        if (accept)
        begin
            byte_valid_next = 1'b1;
        end
        else if (byte_move)
        begin
            byte_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (drain)
        begin
            pend_next = pend_reg & ~first_hot;
        end
        if (byte_move)
        begin
            pend_next = walk_mask;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = drain;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            if (byte_move)
            begin
                state_reg <= walk_state;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg  <= data_byte;
            start_reg <= unit_start;
        end
        if (byte_move)
        begin
            slots_reg <= walk_slots;
        end
        if (drain)
        begin
            // raw holds the leading one plus suffix: drop one to get the value
            code_value_reg <= sel_slot.ovf ? '0 : sel_slot.raw - VALUE_W'(1);
            overflow_reg   <= sel_slot.ovf;
            last_reg       <= (pend_reg & ~first_hot) == '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign code_value   = code_value_reg;
    assign overflow     = overflow_reg;
    assign last_in_byte = last_reg;

    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && overflow_reg |-> code_value_reg == '0)
        else $error("overflow item carries a nonzero value");

    a_prefix_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.zero_count <= ZC_W'(MAX_PREFIX))
        else $error("stored zero count beyond prefix limit");

    a_last_drain: assert property (@(posedge clk) disable iff (!rst_n)
        drain && $onehot(pend_reg) |=> out_valid_reg && last_reg)
        else $error("final codeword of a byte not marked last");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_valid_reg |-> !in_stall)
        else $error("input stalled with empty byte register");

    a_slots_free: assert property (@(posedge clk) disable iff (!rst_n)
        byte_move |=> pend_reg == $past(walk_mask))
        else $error("byte results lost on slot load");

endmodule

@@ sim/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import egd_pkg::*;

    // Cycles in which neither channel moves an item before the run is abandoned.
    // The longest legitimate quiet stretch is a short run of random stalls or
    // idle cycles plus the pipeline's own registers, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEMS_PER_PHASE = 39;
    localparam int DRAIN_CYCLES = 8;
    // A directed row with this count is checked against the predictor.
    localparam int PREDICT = -1;

    typedef enum logic {
        PH_PREFIX,
        PH_SUFFIX
    } phase_e;

    // One decoded codeword as it should appear on the output channel.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               ovf;
        logic               last_flag;
    } codeword_t;

    // One directed stimulus row. When n_typed is not PREDICT, the byte must
    // produce exactly n_typed codewords, all with the typed value and overflow.
    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic               start;
        int                 n_typed;
        logic [VALUE_W-1:0] value;
        logic               ovf;
    } dir_row_t;

    localparam int N_DIRECTED = 24;
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        // Eight lone one bits right after a unit start: eight zeros out.
        '{8'hFF, 1'b1, 8, 32'd0, 1'b0},
        // Thirty-two zeros in a row: the last one flags overflow.
        '{8'h00, 1'b1, 0, 32'd0, 1'b0},
        '{8'h00, 1'b0, 0, 32'd0, 1'b0},
        '{8'h00, 1'b0, 0, 32'd0, 1'b0},
        '{8'h00, 1'b0, 1, 32'd0, 1'b1},
        // Leaves five prefix zeros pending at the end of the byte.
        '{8'h40, 1'b0, PREDICT, 32'd0, 1'b0},
        // Unit start drops the pending prefix; the leading one decodes to zero.
        '{8'h80, 1'b1, 1, 32'd0, 1'b0},
        // Longest legal codeword: 31 zeros, a one, 31 ones -> 2^32 - 2.
        '{8'h00, 1'b1, 0, 32'd0, 1'b0},
        '{8'h00, 1'b0, 0, 32'd0, 1'b0},
        '{8'h00, 1'b0, 0, 32'd0, 1'b0},
        '{8'h01, 1'b0, 0, 32'd0, 1'b0},
        '{8'hFF, 1'b0, 0, 32'd0, 1'b0},
        '{8'hFF, 1'b0, 0, 32'd0, 1'b0},
        '{8'hFF, 1'b0, 0, 32'd0, 1'b0},
        '{8'hFE, 1'b0, 1, 32'hFFFF_FFFE, 1'b0},
        // Mixed short codewords, some spanning byte boundaries.
        '{8'h55, 1'b0, PREDICT, 32'd0, 1'b0},
        '{8'hAA, 1'b0, PREDICT, 32'd0, 1'b0},
        '{8'h2C, 1'b0, PREDICT, 32'd0, 1'b0},
        '{8'h7F, 1'b0, PREDICT, 32'd0, 1'b0},
        '{8'h01, 1'b1, PREDICT, 32'd0, 1'b0},
        '{8'h12, 1'b0, PREDICT, 32'd0, 1'b0},
        '{8'hC3, 1'b0, PREDICT, 32'd0, 1'b0},
        '{8'h00, 1'b1, 0, 32'd0, 1'b0},
        '{8'h0F, 1'b0, PREDICT, 32'd0, 1'b0}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [BYTE_W-1:0]  data_byte = '0;
    logic               unit_start = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [VALUE_W-1:0] code_value;
    logic               overflow;
    logic               last_in_byte;

    // Codewords still owed by the block, oldest first.
    codeword_t pending_codewords[$];
    // Codewords the predictor derived from the most recent byte.
    codeword_t byte_codewords[$];
    // Bits of a well-formed random stream not yet packed into a byte.
    bit        stream_bits[$];

    // Predictor state, one copy of what the decoder carries across bytes.
    phase_e             pred_phase;
    logic [5:0]         pred_zeros;
    logic [4:0]         pred_left;
    logic [VALUE_W-1:0] pred_accum;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int quiet_cycles = 0;

    exp_golomb_ue_decoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .unit_start   (unit_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .code_value   (code_value),
        .overflow     (overflow),
        .last_in_byte (last_in_byte)
    );

    always #5 clk = ~clk;

    function automatic void restart_decode();
        pred_phase = PH_PREFIX;
        pred_zeros = '0;
        pred_left  = '0;
        pred_accum = '0;
    endfunction

    function automatic codeword_t make_codeword(logic [VALUE_W-1:0] v, logic o);
        codeword_t cw;
        cw.value     = v;
        cw.ovf       = o;
        cw.last_flag = 1'b0;
        return cw;
    endfunction

    // Walk one byte MSB first and collect every codeword it completes into
    // byte_codewords, marking the final one.
    function automatic void decode_byte(logic [BYTE_W-1:0] d, logic s);
        logic      bitv;
        codeword_t cw;
        byte_codewords.delete();
        if (s)
            restart_decode();
        for (int b = BYTE_W - 1; b >= 0; b--)
        begin
            bitv = d[b];
            if (pred_phase == PH_PREFIX)
            begin
                if (!bitv)
                begin
                    pred_zeros = pred_zeros + 6'd1;
                    // Prefix too long: flag it and start over with the next bit.
                    if (pred_zeros > MAX_PREFIX)
                    begin
                        byte_codewords.push_back(make_codeword('0, 1'b1));
                        restart_decode();
                    end
                end
                else if (pred_zeros == 0)
                begin
                    byte_codewords.push_back(make_codeword('0, 1'b0));
                end
                else
                begin
                    pred_phase = PH_SUFFIX;
                    pred_left  = pred_zeros[4:0];
                    pred_accum = '0;
                end
            end
            else
            begin
                pred_accum = {pred_accum[VALUE_W-2:0], bitv};
                pred_left  = pred_left - 5'd1;
                if (pred_left == 0)
                begin
                    byte_codewords.push_back(make_codeword(
                        pred_accum + ((32'd1 << pred_zeros[4:0]) - 32'd1), 1'b0));
                    restart_decode();
                end
            end
        end
        if (byte_codewords.size() > 0)
        begin
            cw = byte_codewords.pop_back();
            cw.last_flag = 1'b1;
            byte_codewords.push_back(cw);
        end
    endfunction

    // Pack the next eight bits of a well-formed ue(v) stream. Codeword
    // lengths lean short, with a tail of long ones and a few overlong
    // prefixes that force the overflow path.
    task automatic next_stream_byte(output logic [BYTE_W-1:0] d);
        int r;
        int k;
        while (stream_bits.size() < BYTE_W)
        begin
            r = $urandom_range(99);
            if (r < 60)
                k = $urandom_range(3);
            else if (r < 85)
                k = $urandom_range(12, 4);
            else if (r < 95)
                k = $urandom_range(MAX_PREFIX, 13);
            else
                k = $urandom_range(MAX_PREFIX + 9, MAX_PREFIX + 1);
            repeat (k) stream_bits.push_back(1'b0);
            if (k <= MAX_PREFIX)
            begin
                stream_bits.push_back(1'b1);
                repeat (k) stream_bits.push_back(bit'($urandom_range(1)));
            end
        end
        d = '0;
        repeat (BYTE_W) d = {d[BYTE_W-2:0], stream_bits.pop_front()};
    endtask

    // Offer one byte, hold it until accepted, then queue what it must yield.
    task automatic send_byte(input logic [BYTE_W-1:0] d, input logic s,
                             input int n_typed, input logic [VALUE_W-1:0] t_value,
                             input logic t_ovf);
        codeword_t cw;
        // Idle the sender for a random stretch first.
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= d;
        unit_start <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // Accepted at this edge; advance the predictor regardless so its
        // state stays in step on typed rows too.
        decode_byte(d, s);
        if (n_typed == PREDICT)
        begin
            foreach (byte_codewords[i])
                pending_codewords.push_back(byte_codewords[i]);
        end
        else
        begin
            for (int i = 0; i < n_typed; i++)
            begin
                cw = make_codeword(t_value, t_ovf);
                cw.last_flag = (i == n_typed - 1);
                pending_codewords.push_back(cw);
            end
        end
    endtask

    // Output side: check each accepted codeword against the oldest one owed,
    // redraw the stall, and run the watchdog. Values read here are the ones
    // from before the edge, since the block and the drivers update by NBA.
    always @(posedge clk)
    begin
        codeword_t cw;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_codewords.size() == 0)
                begin
                    $error("unexpected codeword: code_value=%0h overflow=%0b last_in_byte=%0b",
                           code_value, overflow, last_in_byte);
                    errors++;
                end
                else
                begin
                    cw = pending_codewords.pop_front();
                    if (code_value !== cw.value)
                    begin
                        $error("code_value: expected %0h, got %0h", cw.value, code_value);
                        errors++;
                    end
                    if (overflow !== cw.ovf)
                    begin
                        $error("overflow: expected %0b, got %0b", cw.ovf, overflow);
                        errors++;
                    end
                    if (last_in_byte !== cw.last_flag)
                    begin
                        $error("last_in_byte: expected %0b, got %0b",
                               cw.last_flag, last_in_byte);
                        errors++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);

            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [BYTE_W-1:0] d;
        logic              s;
        int                r;

        restart_decode();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows, with both sides running flat out.
        foreach (DIRECTED[i])
            send_byte(DIRECTED[i].data, DIRECTED[i].start, DIRECTED[i].n_typed,
                      DIRECTED[i].value, DIRECTED[i].ovf);

        // Random part in four idling phases: none, sender idle, receiver
        // stalling, and both at once.
        stream_bits.delete();
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 55 : (ph == 3) ? 24 : 0;
            recv_stall_pct = (ph == 2) ? 55 : (ph == 3) ? 24 : 0;
            repeat (ITEMS_PER_PHASE)
            begin
                r = $urandom_range(99);
                if (r < 75)
                begin
                    // Well-formed stream, continuing across bytes.
                    next_stream_byte(d);
                    s = 1'b0;
                end
                else if (r < 88)
                begin
                    // Noise: a random byte that knocks the stream off alignment.
                    d = BYTE_W'($urandom_range(255));
                    s = 1'b0;
                end
                else if (r < 95)
                begin
                    // Unit start: drop the partial stream and realign.
                    stream_bits.delete();
                    next_stream_byte(d);
                    s = 1'b1;
                end
                else
                begin
                    // Unit start on a random byte.
                    stream_bits.delete();
                    d = BYTE_W'($urandom_range(255));
                    s = 1'b1;
                end
                send_byte(d, s, PREDICT, '0, 1'b0);
            end
        end
        in_valid <= 1'b0;

        // Drain every owed codeword, then hold a little longer to catch extras.
        while (pending_codewords.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/egd_pkg.sv
rtl/core/egd_walk.sv
rtl/core/exp_golomb_ue_decoder.sv
sim/tb.sv
